// File: hw/rtl/cfrp_pkg.sv
package cfrp_pkg;

	// Field and port widths
	localparam int CoordW    = 12;
	localparam int DimW      = 13;
	localparam int PixW      = 8;
	localparam int CfgIndexW = 4;
	localparam int CfgDataW  = 13;
	localparam int NumWatch  = 4;

	// Largest frame dimension; width and height saturate here
	localparam int MaxDim = 4096;

	// One quotient bit per dividend bit
	localparam int DivSteps = DimW;
	localparam int DivCntW  = $clog2(DivSteps);
	localparam int DivisorW = CoordW + 3;

	// Register indexes of the configuration port
	typedef enum logic [CfgIndexW-1:0] {
		RegColumnStep     = 4'd0,
		RegFrameWidth     = 4'd1,
		RegFrameHeight    = 4'd2,
		RegWhiteThreshold = 4'd3
	} cfg_reg_t;

	// Register values after reset
	localparam int RstColumnStep     = 100;
	localparam int RstFrameWidth     = 640;
	localparam int RstFrameHeight    = 480;
	localparam int RstWhiteThreshold = 127;

	// Watched columns that follow from the reset registers
	localparam int RstPeriod =
		((RstFrameWidth + RstColumnStep - 1) / RstColumnStep) / 6;
	localparam int CoordMod  = 1 << CoordW;
	localparam int RstWatch0 = (1 * RstPeriod * RstColumnStep) % CoordMod;
	localparam int RstWatch1 = (2 * RstPeriod * RstColumnStep) % CoordMod;
	localparam int RstWatch2 = (4 * RstPeriod * RstColumnStep) % CoordMod;
	localparam int RstWatch3 = (5 * RstPeriod * RstColumnStep) % CoordMod;

	typedef logic [NumWatch-1:0][CoordW-1:0] watch_t;

	typedef struct packed {
		logic [PixW-1:0] pixel;
		logic            frame_start;
	} in_t;

	typedef struct packed {
		logic              all_found;
		logic [CoordW-1:0] x_left_a;
		logic [CoordW-1:0] y_left_a;
		logic [CoordW-1:0] x_left_b;
		logic [CoordW-1:0] y_left_b;
		logic [CoordW-1:0] x_right_a;
		logic [CoordW-1:0] y_right_a;
		logic [CoordW-1:0] x_right_b;
		logic [CoordW-1:0] y_right_b;
		logic [CoordW-1:0] left_thickness;
		logic [CoordW-1:0] right_thickness;
	} out_t;

	// Settings the pixel path reads from the configuration unit
	typedef struct packed {
		logic            busy;
		logic [DimW-1:0] width_c;
		logic [DimW-1:0] height_c;
		logic [PixW-1:0] thresh;
	} cfg_stat_t;

endpackage

// File: hw/rtl/column_first_run_profiler.sv
// Channel  Direction  Handshake                Payload
// in       sink       in_valid / in_ready      cfrp_pkg::in_t   (pixel, frame_start)
// out      source     out_valid / out_ready    cfrp_pkg::out_t  (one item per frame)
// cfg      sink       cfg_valid / cfg_ready    cfg_index, cfg_data
//
// One pixel per clock while the input is not stalled: input register, then the run update and the result register.
// A known register write recomputes the watched columns (load, 13-step
// divider, multiply); in_ready and cfg_ready stay low while it runs.
// Reset loads the default registers and their watched columns at once; no clearing pass.
// Besides the recompute, the input stalls only when a frame's last pixel meets a result still waiting.
module column_first_run_profiler #(
	parameter int MaxDim = cfrp_pkg::MaxDim
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  cfrp_pkg::in_t                  in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output cfrp_pkg::out_t                 out_data,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [cfrp_pkg::CfgIndexW-1:0] cfg_index,
	input  logic [cfrp_pkg::CfgDataW-1:0]  cfg_data
);

	localparam int CW = cfrp_pkg::CoordW;
	localparam int DW = cfrp_pkg::DimW;
	localparam int NW = cfrp_pkg::NumWatch;

	cfrp_pkg::cfg_stat_t stat;
	cfrp_pkg::watch_t    watched;

	cfrp_cfg_unit #(
		.MaxDim (MaxDim)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.stat      (stat),
		.watched   (watched)
	);

	// Input register
	logic                      v_s1;
	logic [cfrp_pkg::PixW-1:0] pix_s1;
	logic                      fs_s1;

	// Frame position and run state
	logic [CW-1:0]          col_q;
	logic [CW-1:0]          row_q;
	logic [NW-1:0][CW-1:0]  top_q;
	logic [NW-1:0][CW-1:0]  last_q;
	logic [NW-1:0]          seen_q;
	logic [NW-1:0]          closed_q;

	// Result register
	logic           out_valid_q;
	cfrp_pkg::out_t out_q;

	logic                  in_acc;
	logic                  s1_go;
	logic [CW-1:0]         col_e;
	logic [CW-1:0]         row_e;
	logic [NW-1:0]         seen_e;
	logic [NW-1:0]         closed_e;
	logic                  white;
	logic [NW-1:0]         hit;
	logic [NW-1:0]         seen_n;
	logic [NW-1:0]         closed_n;
	logic [NW-1:0][CW-1:0] top_n;
	logic [NW-1:0][CW-1:0] last_n;
	logic [DW-1:0]         col_inc;
	logic [DW-1:0]         row_inc;
	logic                  wrap;
	logic                  frame_end;
	cfrp_pkg::out_t        res;

	// Frame start drops the partial frame and makes this pixel row 0, column 0
	assign col_e    = fs_s1 ? '0 : col_q;
	assign row_e    = fs_s1 ? '0 : row_q;
	assign seen_e   = fs_s1 ? '0 : seen_q;
	assign closed_e = fs_s1 ? '0 : closed_q;
	assign white    = (pix_s1 > stat.thresh);

	// Update the first run of each watched column
	always_comb begin
		for (int k = 0; k < NW; k++) begin
			hit[k]      = (col_e == watched[k]) && !closed_e[k];
			seen_n[k]   = seen_e[k];
			closed_n[k] = closed_e[k];
			top_n[k]    = top_q[k];
			last_n[k]   = last_q[k];
			if (hit[k] && white) begin
				seen_n[k] = 1'b1;
				if (!seen_e[k]) begin
					top_n[k] = row_e;
				end
				last_n[k] = row_e;
			end else if (hit[k] && seen_e[k]) begin
				closed_n[k] = 1'b1;
			end
		end
	end

	// Advance the raster position
	assign col_inc   = {1'b0, col_e} + DW'(1);
	assign row_inc   = {1'b0, row_e} + DW'(1);
	assign wrap      = (col_inc >= stat.width_c);
	assign frame_end = wrap && (row_inc >= stat.height_c);

	// Form the frame result
	always_comb begin
		res.all_found       = &seen_n;
		res.x_left_a        = watched[0];
		res.y_left_a        = seen_n[0] ? top_n[0] : '0;
		res.x_left_b        = watched[1];
		res.y_left_b        = seen_n[1] ? top_n[1] : '0;
		res.x_right_a       = watched[2];
		res.y_right_a       = seen_n[2] ? top_n[2] : '0;
		res.x_right_b       = watched[3];
		res.y_right_b       = seen_n[3] ? top_n[3] : '0;
		res.left_thickness  = seen_n[0] ? CW'(last_n[0] - top_n[0]) : '0;
		res.right_thickness = seen_n[2] ? CW'(last_n[2] - top_n[2]) : '0;
	end

	// Hold the pixel only when its result has nowhere to go
	assign s1_go    = v_s1 && !(frame_end && out_valid_q && !out_ready);
	assign in_ready = !stat.busy && (!v_s1 || s1_go);
	assign in_acc   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			col_q       <= '0;
			row_q       <= '0;
			seen_q      <= '0;
			closed_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				v_s1 <= 1'b1;
			end else if (s1_go) begin
				v_s1 <= 1'b0;
			end
			if (s1_go) begin
				if (frame_end) begin
					col_q    <= '0;
					row_q    <= '0;
					seen_q   <= '0;
					closed_q <= '0;
				end else begin
					col_q    <= wrap ? '0 : col_inc[CW-1:0];
					row_q    <= wrap ? row_inc[CW-1:0] : row_e;
					seen_q   <= seen_n;
					closed_q <= closed_n;
				end
			end
			if (s1_go && frame_end) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			pix_s1 <= in_data.pixel;
			fs_s1  <= in_data.frame_start;
		end
		if (s1_go) begin
			top_q  <= top_n;
			last_q <= last_n;
		end
		if (s1_go && frame_end) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// File: hw/rtl/cfrp_cfg_unit.sv
module cfrp_cfg_unit #(
	parameter int MaxDim = cfrp_pkg::MaxDim
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [cfrp_pkg::CfgIndexW-1:0] cfg_index,
	input  logic [cfrp_pkg::CfgDataW-1:0]  cfg_data,
	output cfrp_pkg::cfg_stat_t           stat,
	output cfrp_pkg::watch_t              watched
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DIV,
		ST_MUL
	} state_t;

	localparam int CW = cfrp_pkg::CoordW;
	localparam int DW = cfrp_pkg::DimW;
	localparam int VW = cfrp_pkg::DivisorW;

	state_t                        state_q;
	logic [cfrp_pkg::DivCntW-1:0]  cnt_q;
	logic [CW-1:0]                 step_q;
	logic [DW-1:0]                 width_q;
	logic [DW-1:0]                 height_q;
	logic [cfrp_pkg::PixW-1:0]     thresh_q;
	cfrp_pkg::watch_t              watched_q;

	logic [DW-1:0] dvd_q;
	logic [VW-1:0] dvs_q;
	logic [VW-1:0] rem_q;
	logic [DW-1:0] quo_q;

	logic [CW-1:0]    step_c;
	logic [DW-1:0]    width_c;
	logic [DW-1:0]    height_c;
	logic [DW:0]      dividend_w;
	logic [VW-1:0]    divisor_c;
	logic [VW:0]      trial;
	logic [VW:0]      diff;
	logic             fits;
	logic [VW-1:0]    rem_n;
	logic [DW+CW-1:0] prod;
	logic [CW-1:0]    ps;
	cfrp_pkg::watch_t watched_n;
	logic             wr_en;
	logic             wr_known;

	function automatic logic [DW-1:0] clamp_dim(input logic [DW-1:0] v);
		if (v == '0) begin
			return DW'(1);
		end else if (32'(v) > MaxDim) begin
			return DW'(MaxDim);
		end
		return v;
	endfunction

	// Clamp the raw registers
	assign step_c   = (step_q == '0) ? CW'(1) : step_q;
	assign width_c  = clamp_dim(width_q);
	assign height_c = clamp_dim(height_q);

	// Sampled column count over six is floor((w + s - 1) / (6 s))
	assign dividend_w = {1'b0, width_c} + {2'b00, step_c} - (DW+1)'(1);
	assign divisor_c  = ({3'b000, step_c} << 2) + ({3'b000, step_c} << 1);

	// One restoring division step
	assign trial = {rem_q, dvd_q[DW-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = (trial >= {1'b0, dvs_q});
	assign rem_n = fits ? diff[VW-1:0] : trial[VW-1:0];

	// Scale the period by the step; multiples taken modulo the coordinate range
	assign prod = {{CW{1'b0}}, quo_q} * {{DW{1'b0}}, step_c};
	assign ps   = prod[CW-1:0];
	assign watched_n[0] = ps;
	assign watched_n[1] = {ps[CW-2:0], 1'b0};
	assign watched_n[2] = {ps[CW-3:0], 2'b00};
	assign watched_n[3] = ps + {ps[CW-3:0], 2'b00};

	assign cfg_ready = (state_q == ST_IDLE);
	assign wr_en     = cfg_valid && cfg_ready;
	assign wr_known  = (cfg_index == cfrp_pkg::RegColumnStep) ||
		(cfg_index == cfrp_pkg::RegFrameWidth) ||
		(cfg_index == cfrp_pkg::RegFrameHeight) ||
		(cfg_index == cfrp_pkg::RegWhiteThreshold);

	// Hold registers, sequence the recompute of the watched columns
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			step_q    <= CW'(cfrp_pkg::RstColumnStep);
			width_q   <= DW'(cfrp_pkg::RstFrameWidth);
			height_q  <= DW'(cfrp_pkg::RstFrameHeight);
			thresh_q  <= cfrp_pkg::PixW'(cfrp_pkg::RstWhiteThreshold);
			watched_q[0] <= CW'(cfrp_pkg::RstWatch0);
			watched_q[1] <= CW'(cfrp_pkg::RstWatch1);
			watched_q[2] <= CW'(cfrp_pkg::RstWatch2);
			watched_q[3] <= CW'(cfrp_pkg::RstWatch3);
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (wr_en) begin
						unique case (cfg_index)
							cfrp_pkg::RegColumnStep:     step_q   <= cfg_data[CW-1:0];
							cfrp_pkg::RegFrameWidth:     width_q  <= cfg_data[DW-1:0];
							cfrp_pkg::RegFrameHeight:    height_q <= cfg_data[DW-1:0];
							cfrp_pkg::RegWhiteThreshold: thresh_q <= cfg_data[cfrp_pkg::PixW-1:0];
							default: ;
						endcase
						if (wr_known) begin
							state_q <= ST_LOAD;
						end
					end
				end
				ST_LOAD: begin
					cnt_q   <= cfrp_pkg::DivCntW'(cfrp_pkg::DivSteps - 1);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						state_q <= ST_MUL;
					end else begin
						cnt_q <= cnt_q - cfrp_pkg::DivCntW'(1);
					end
				end
				ST_MUL: begin
					watched_q <= watched_n;
					state_q   <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Divider datapath
	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD) begin
			dvd_q <= dividend_w[DW-1:0];
			dvs_q <= divisor_c;
			rem_q <= '0;
			quo_q <= '0;
		end else if (state_q == ST_DIV) begin
			dvd_q <= {dvd_q[DW-2:0], 1'b0};
			rem_q <= rem_n;
			quo_q <= {quo_q[DW-2:0], fits};
		end
	end

	assign stat.busy     = (state_q != ST_IDLE);
	assign stat.width_c  = width_c;
	assign stat.height_c = height_c;
	assign stat.thresh   = thresh_q;
	assign watched       = watched_q;

endmodule

// File: hw/rtl/cfrp_checker.sv
module cfrp_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input cfrp_pkg::in_t                  in_data,
	input logic                           out_valid,
	input logic                           out_ready,
	input cfrp_pkg::out_t                 out_data,
	input logic                           cfg_valid,
	input logic                           cfg_ready,
	input logic [cfrp_pkg::CfgIndexW-1:0] cfg_index,
	input logic [cfrp_pkg::CfgDataW-1:0]  cfg_data
);

	localparam int CW = cfrp_pkg::CoordW;

	// A waiting result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// A known register write starts the recompute and blocks both inputs
	a_cfg_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready &&
		(cfg_index == cfrp_pkg::RegColumnStep || cfg_index == cfrp_pkg::RegFrameWidth ||
		 cfg_index == cfrp_pkg::RegFrameHeight || cfg_index == cfrp_pkg::RegWhiteThreshold)
		|=> !cfg_ready && !in_ready)
		else $error("no recompute after register write");

	// Pixels wait while the watched columns are recomputed
	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg_ready |-> !in_ready)
		else $error("pixel accepted during recompute");

	// Watched columns are 1, 2, 4 and 5 times one period
	a_cols: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |->
		out_data.x_left_b == {out_data.x_left_a[CW-2:0], 1'b0} &&
		out_data.x_right_a == {out_data.x_left_a[CW-3:0], 2'b00} &&
		out_data.x_right_b == CW'(out_data.x_left_a + out_data.x_right_a))
		else $error("watched columns inconsistent");

endmodule

bind column_first_run_profiler cfrp_checker u_cfrp_checker (.*);

// File: test/run_profile_checker.sv
module run_profile_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  cfrp_pkg::in_t                  in_data,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  cfrp_pkg::out_t                 out_data,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [cfrp_pkg::CfgIndexW-1:0] cfg_index,
	input  logic [cfrp_pkg::CfgDataW-1:0]  cfg_data,
	output int                             mismatches,
	output int                             profiles_waiting,
	output int                             profiles_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CoordW = cfrp_pkg::CoordW;
	localparam int DimW = cfrp_pkg::DimW;
	localparam int PixW = cfrp_pkg::PixW;
	localparam int NumWatch = cfrp_pkg::NumWatch;
	localparam int MaxDim = cfrp_pkg::MaxDim;
	localparam int NumFields = 11;
	localparam int MaxReports = 10;

	// Mirrored registers
	logic [CoordW-1:0] col_step;
	logic [DimW-1:0]   width_raw;
	logic [DimW-1:0]   height_raw;
	logic [PixW-1:0]   thresh;

	// Mirrored frame position and per-column run state
	logic [CoordW-1:0] watch [NumWatch];
	int                col_pos;
	int                row_pos;
	logic [CoordW-1:0] run_top [NumWatch];
	logic [CoordW-1:0] run_last [NumWatch];
	logic              run_seen [NumWatch];
	logic              run_closed [NumWatch];

	cfrp_pkg::out_t expected_profiles [$];

	function automatic int dim_of(logic [DimW-1:0] raw);
		if (raw == 0)
			return 1;
		if (raw > MaxDim)
			return MaxDim;
		return raw;
	endfunction

	// Place the four watched columns at p, 2p, 4p and 5p sampled columns
	function automatic void place_watch();
		int step;
		int cols;
		int period;
		step = (col_step == 0) ? 1 : col_step;
		cols = (dim_of(width_raw) + step - 1) / step;
		period = cols / 6;
		watch[0] = CoordW'(period * step);
		watch[1] = CoordW'(2 * period * step);
		watch[2] = CoordW'(4 * period * step);
		watch[3] = CoordW'(5 * period * step);
	endfunction

	function automatic void restart_frame();
		col_pos = 0;
		row_pos = 0;
		for (int k = 0; k < NumWatch; k++) begin
			run_top[k] = '0;
			run_last[k] = '0;
			run_seen[k] = 1'b0;
			run_closed[k] = 1'b0;
		end
	endfunction

	// Advance by one pixel; queue a profile when the frame completes
	function automatic void take_pixel(cfrp_pkg::in_t px);
		logic white;
		cfrp_pkg::out_t prof;
		if (px.frame_start)
			restart_frame();
		white = px.pixel > thresh;
		for (int k = 0; k < NumWatch; k++) begin
			if (col_pos == watch[k] && !run_closed[k]) begin
				if (white) begin
					if (!run_seen[k]) begin
						run_seen[k] = 1'b1;
						run_top[k] = CoordW'(row_pos);
					end
					run_last[k] = CoordW'(row_pos);
				end else if (run_seen[k]) begin
					run_closed[k] = 1'b1;
				end
			end
		end
		col_pos++;
		if (col_pos < dim_of(width_raw))
			return;
		col_pos = 0;
		row_pos++;
		if (row_pos < dim_of(height_raw))
			return;
		prof.all_found = run_seen[0] & run_seen[1] & run_seen[2] & run_seen[3];
		prof.x_left_a = watch[0];
		prof.y_left_a = run_seen[0] ? run_top[0] : '0;
		prof.x_left_b = watch[1];
		prof.y_left_b = run_seen[1] ? run_top[1] : '0;
		prof.x_right_a = watch[2];
		prof.y_right_a = run_seen[2] ? run_top[2] : '0;
		prof.x_right_b = watch[3];
		prof.y_right_b = run_seen[3] ? run_top[3] : '0;
		prof.left_thickness = run_seen[0] ? run_last[0] - run_top[0] : '0;
		prof.right_thickness = run_seen[2] ? run_last[2] - run_top[2] : '0;
		expected_profiles.insert(expected_profiles.size(), prof);
		restart_frame();
	endfunction

	function automatic logic [CoordW-1:0] field_at(cfrp_pkg::out_t r, int i);
		case (i)
			0: return CoordW'(r.all_found);
			1: return r.x_left_a;
			2: return r.y_left_a;
			3: return r.x_left_b;
			4: return r.y_left_b;
			5: return r.x_right_a;
			6: return r.y_right_a;
			7: return r.x_right_b;
			8: return r.y_right_b;
			9: return r.left_thickness;
			default: return r.right_thickness;
		endcase
	endfunction

	function automatic string field_name(int i);
		case (i)
			0: return "all_found";
			1: return "x_left_a";
			2: return "y_left_a";
			3: return "x_left_b";
			4: return "y_left_b";
			5: return "x_right_a";
			6: return "y_right_a";
			7: return "x_right_b";
			8: return "y_right_b";
			9: return "left_thickness";
			default: return "right_thickness";
		endcase
	endfunction

	// Compare an arriving profile with the oldest one expected
	function automatic void check_profile(cfrp_pkg::out_t got);
		cfrp_pkg::out_t want;
		logic bad;
		if (expected_profiles.size() == 0) begin
			if (mismatches < MaxReports)
				$display("%0t: profile %h arrived with none expected", $time, got);
			mismatches++;
			return;
		end
		want = expected_profiles.pop_front();
		bad = 1'b0;
		for (int i = 0; i < NumFields; i++) begin
			if (field_at(got, i) !== field_at(want, i)) begin
				if (mismatches < MaxReports)
					$display("%0t: profile field %s expected %0d, got %0d", $time,
						field_name(i), field_at(want, i), field_at(got, i));
				bad = 1'b1;
			end
		end
		if (bad)
			mismatches++;
	endfunction

	// Track register writes, pixels and profiles at each edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_step = CoordW'(cfrp_pkg::RstColumnStep);
			width_raw = DimW'(cfrp_pkg::RstFrameWidth);
			height_raw = DimW'(cfrp_pkg::RstFrameHeight);
			thresh = PixW'(cfrp_pkg::RstWhiteThreshold);
			restart_frame();
			place_watch();
			expected_profiles.delete();
			mismatches = 0;
			profiles_seen = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					cfrp_pkg::RegColumnStep:     col_step = cfg_data[CoordW-1:0];
					cfrp_pkg::RegFrameWidth:     width_raw = cfg_data[DimW-1:0];
					cfrp_pkg::RegFrameHeight:    height_raw = cfg_data[DimW-1:0];
					cfrp_pkg::RegWhiteThreshold: thresh = cfg_data[PixW-1:0];
					default: ;
				endcase
				place_watch();
			end
			if (in_valid && in_ready)
				take_pixel(in_data);
			if (out_valid && out_ready) begin
				check_profile(out_data);
				profiles_seen++;
			end
		end
		profiles_waiting = expected_profiles.size();
	end

endmodule

// File: test/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PixW = cfrp_pkg::PixW;
	localparam int CoordW = cfrp_pkg::CoordW;
	localparam int CfgIndexW = cfrp_pkg::CfgIndexW;
	localparam int CfgDataW = cfrp_pkg::CfgDataW;
	localparam int MaxDim = cfrp_pkg::MaxDim;
	localparam int RstFrameWidth = cfrp_pkg::RstFrameWidth;
	localparam int RstWhiteThreshold = cfrp_pkg::RstWhiteThreshold;
	localparam int LongHold = 300;
	localparam int PressurePixels = 40;
	localparam int LargeCut = 32;
	localparam int RandomPixels = 150;
	localparam int RandomProfiles = 10;
	localparam int QuietPixels = 60;
	localparam int DrainCycles = 8;
	localparam int PixMax = (1 << PixW) - 1;
	localparam int CoordMax = (1 << CoordW) - 1;
	localparam int DataMax = (1 << CfgDataW) - 1;

	typedef enum int {
		ShadeNoise,
		ShadeBand,
		ShadeTwoBands,
		ShadeBright,
		ShadeDark
	} shade_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	cfrp_pkg::in_t        in_data;
	logic                 out_valid;
	logic                 out_ready;
	cfrp_pkg::out_t       out_data;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CfgIndexW-1:0] cfg_index;
	logic [CfgDataW-1:0]  cfg_data;
	int                   mismatches;
	int                   profiles_waiting;
	int                   profiles_seen;

	// Frame geometry the stimulus is shaped for
	int            frame_w;
	int            frame_h;
	logic [PixW-1:0] thresh;
	logic          aligned = 1'b1;
	logic          quiet = 1'b0;
	logic          hold_req = 1'b0;
	logic          hold_done = 1'b0;
	int            pixels_sent = 0;
	int            cfg_writes = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	column_first_run_profiler u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	run_profile_checker u_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.in_data          (in_data),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.out_data         (out_data),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.mismatches       (mismatches),
		.profiles_waiting (profiles_waiting),
		.profiles_seen    (profiles_seen)
	);

	function automatic int eff_dim(logic [CfgDataW-1:0] raw);
		if (raw == 0)
			return 1;
		if (raw > MaxDim)
			return MaxDim;
		return raw;
	endfunction

	function automatic logic [PixW-1:0] bright_pixel();
		if (thresh == PixMax)
			return PixW'(PixMax);
		return PixW'($urandom_range(int'(thresh) + 1, PixMax));
	endfunction

	function automatic logic [PixW-1:0] dull_pixel();
		return PixW'($urandom_range(0, int'(thresh)));
	endfunction

	// Offer one pixel item, with an occasional gap first, and wait for it to go in
	task automatic send_pixel(logic [PixW-1:0] pix, logic fs);
		cfrp_pkg::in_t item;
		item.pixel = pix;
		item.frame_start = fs;
		@(negedge clk);
		if (!quiet && $urandom_range(0, 7) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		in_valid = 1'b1;
		in_data = item;
		do @(posedge clk); while (!in_ready);
		pixels_sent++;
	endtask

	task automatic stop_pixels();
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic write_reg(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
		cfg_writes++;
	endtask

	// Let every profile come out and the pipeline settle, then write all registers
	task automatic set_config(logic [CfgDataW-1:0] step_d, logic [CfgDataW-1:0] w_d,
			logic [CfgDataW-1:0] h_d, logic [CfgDataW-1:0] thr_d);
		stop_pixels();
		while (profiles_waiting != 0) @(negedge clk);
		repeat (DrainCycles) @(negedge clk);
		if ($urandom_range(0, 3) == 0)
			write_reg(CfgIndexW'($urandom_range(cfrp_pkg::RegWhiteThreshold + 1,
				(1 << CfgIndexW) - 1)), CfgDataW'($urandom));
		write_reg(cfrp_pkg::RegColumnStep, step_d);
		write_reg(cfrp_pkg::RegFrameWidth, w_d);
		write_reg(cfrp_pkg::RegFrameHeight, h_d);
		write_reg(cfrp_pkg::RegWhiteThreshold, thr_d);
		frame_w = eff_dim(w_d);
		frame_h = eff_dim(h_d);
		thresh = thr_d[PixW-1:0];
	endtask

	// Send one frame in raster order; stop early after cut pixels when cut is nonzero
	task automatic send_frame(shade_t shade, logic with_start, int cut, int first_row,
			int last_row);
		int sent;
		logic lit;
		aligned = 1'b0;
		if (first_row < 0) begin
			first_row = $urandom_range(0, frame_h - 1);
			last_row = $urandom_range(first_row, frame_h - 1);
		end
		sent = 0;
		for (int r = 0; r < frame_h; r++) begin
			for (int c = 0; c < frame_w; c++) begin
				if (cut != 0 && sent == cut)
					return;
				case (shade)
					ShadeBand:     lit = r >= first_row + c % 2 && r <= last_row;
					ShadeTwoBands: lit = r == first_row || (r >= first_row + 2 && r <= last_row);
					ShadeBright:   lit = 1'b1;
					ShadeDark:     lit = 1'b0;
					default:       lit = 1'($urandom_range(0, 1));
				endcase
				// flip a few pixels so runs break up now and then
				if (shade == ShadeBand && $urandom_range(0, 15) == 0)
					lit = !lit;
				send_pixel(lit ? bright_pixel() : dull_pixel(), with_start && sent == 0);
				sent++;
			end
		end
		aligned = 1'b1;
	endtask

	// Pick small frames mostly, with zero and extreme register values mixed in
	task automatic random_config();
		logic [CfgDataW-1:0] step_d;
		logic [CfgDataW-1:0] w_d;
		logic [CfgDataW-1:0] h_d;
		logic [CfgDataW-1:0] thr_d;
		case ($urandom_range(0, 9))
			0:       step_d = '0;
			1:       step_d = CfgDataW'(CoordMax);
			2, 3:    step_d = CfgDataW'($urandom_range(2, 3));
			default: step_d = 1;
		endcase
		// bits above the register width are dropped by the block
		step_d[CoordW] = 1'($urandom_range(0, 1));
		case ($urandom_range(0, 9))
			0:       w_d = '0;
			1:       w_d = CfgDataW'($urandom_range(15, 30));
			default: w_d = CfgDataW'($urandom_range(1, 14));
		endcase
		h_d = ($urandom_range(0, 9) == 0) ? '0 : CfgDataW'($urandom_range(1, 6));
		case ($urandom_range(0, 5))
			0:       thr_d = '0;
			1:       thr_d = CfgDataW'(PixMax);
			default: thr_d = CfgDataW'($urandom_range(0, PixMax));
		endcase
		thr_d[CfgDataW-1:PixW] = (CfgDataW-PixW)'($urandom);
		set_config(step_d, w_d, h_d, thr_d);
	endtask

	// Drive the receiver: random stalls, one long hold-off on request
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				out_ready = 1'b0;
				for (int n = 1; n < LongHold; n++)
					@(negedge clk);
				hold_done = 1'b1;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				out_ready = 1'b0;
				repeat ($urandom_range(1, 10) - 1) @(negedge clk);
			end else begin
				out_ready = 1'b1;
			end
		end
	end

	initial begin
		#10_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		int pixel_goal;
		int profile_goal;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset width, step and threshold on single-row frames
		write_reg(CfgIndexW'(cfrp_pkg::RegWhiteThreshold + 1), CfgDataW'(DataMax));
		write_reg(cfrp_pkg::RegFrameHeight, 1);
		frame_w = RstFrameWidth;
		frame_h = 1;
		thresh = PixW'(RstWhiteThreshold);
		send_frame(ShadeNoise, 1'b1, 0, -1, -1);

		// Watched columns 1, 2, 4, 5 in a six-column frame
		set_config(1, 6, 3, CfgDataW'(RstWhiteThreshold));
		send_frame(ShadeBright, 1'b1, 0, -1, -1);
		send_frame(ShadeDark, 1'b0, 0, -1, -1);
		send_frame(ShadeTwoBands, 1'b1, 0, 0, 2);
		send_frame(ShadeBright, 1'b1, 7, -1, -1);
		send_frame(ShadeBand, 1'b1, 0, -1, -1);

		// Too few sampled columns: all four watched columns fall on column zero
		set_config(CfgDataW'(CoordMax), 5, 2, 0);
		send_frame(ShadeNoise, 1'b1, 0, -1, -1);

		// Zero step and zero sizes: every pixel is a whole frame, nothing is white
		set_config(0, 0, 0, CfgDataW'(PixMax));
		send_pixel(PixW'(PixMax), 1'b1);
		send_pixel('0, 1'b0);
		send_pixel(PixW'(PixMax), 1'b0);

		// Hold the receiver off while one-pixel frames keep coming
		set_config(1, 1, 1, CfgDataW'(RstWhiteThreshold));
		hold_req = 1'b1;
		repeat (PressurePixels)
			send_pixel(PixW'($urandom), 1'($urandom_range(0, 1)));

		// Largest sizes: the opening of each frame, then a restart drops it
		set_config(1, CfgDataW'(MaxDim), 1, CfgDataW'($urandom_range(0, PixMax)));
		send_frame(ShadeNoise, 1'b1, LargeCut, -1, -1);
		set_config(CfgDataW'(CoordMax), CfgDataW'(DataMax), 1,
			CfgDataW'($urandom_range(0, PixMax)));
		send_frame(ShadeBand, 1'b1, LargeCut, -1, -1);
		set_config(0, 1, CfgDataW'(DataMax), CfgDataW'(RstWhiteThreshold));
		send_frame(ShadeBright, 1'b1, LargeCut, -1, -1);
		send_frame(ShadeBand, 1'b0, LargeCut, -1, -1);

		// Random phases of small frames, partial frames and loose pixels
		pixel_goal = pixels_sent + RandomPixels;
		profile_goal = profiles_seen + RandomProfiles;
		while (pixels_sent < pixel_goal || profiles_seen < profile_goal) begin
			random_config();
			repeat ($urandom_range(3, 8)) begin
				case ($urandom_range(0, 9))
					0: send_frame(shade_t'($urandom_range(ShadeNoise, ShadeDark)), 1'b1,
						$urandom_range(1, frame_w * frame_h), -1, -1);
					1: begin
						repeat ($urandom_range(1, 8))
							send_pixel(PixW'($urandom), $urandom_range(0, 7) == 0);
						aligned = 1'b0;
					end
					default: send_frame(shade_t'($urandom_range(ShadeNoise, ShadeDark)),
						!aligned || $urandom_range(0, 3) != 0, 0, -1, -1);
				endcase
			end
		end

		// Finish with no stalls on either side
		quiet = 1'b1;
		random_config();
		pixel_goal = pixels_sent + QuietPixels;
		while (pixels_sent < pixel_goal)
			send_frame(shade_t'($urandom_range(ShadeNoise, ShadeDark)), 1'b1, 0, -1, -1);

		stop_pixels();
		while (profiles_waiting != 0) @(negedge clk);
		repeat (DrainCycles) @(negedge clk);
		$display("Sent %0d pixels, checked %0d frame profiles, made %0d register writes,",
			pixels_sent, profiles_seen, cfg_writes);
		$display("from one-pixel frames up to cut-short frames at the largest sizes.");
		if (mismatches == 0 && profiles_waiting == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
